>>> rtl/assert_macros.svh
// Assertion helpers; clk and arst_n must be in scope where these are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_AT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

>>> rtl/bezier_pkg.sv
package bezier_pkg;

	localparam logic [16:0] ONE_Q16  = 17'd65536;
	localparam logic [33:0] HALF_LSB = 34'd32768;

	typedef enum logic [1:0] {
		CMD_LOAD = 2'd0,
		CMD_EVAL = 2'd1,
		CMD_ERR  = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_POW  = 8'b0000_0010,
		ST_WGT  = 8'b0000_0100,
		ST_RND  = 8'b0000_1000,
		ST_DIF  = 8'b0001_0000,
		ST_SQ   = 8'b0010_0000,
		ST_ACC  = 8'b0100_0000,
		ST_OUT  = 8'b1000_0000
	} state_t;

	// Q1.16 product rounded back to Q1.16; both operands are at most one.
	function automatic logic [16:0] rnd16(input logic [16:0] a, input logic [16:0] b);
		logic [33:0] p;
		p = 34'(a) * 34'(b) + HALF_LSB;
		return p[32:16];
	endfunction

endpackage

>>> rtl/bezier_curve_eval_error.sv
// Bezier curve evaluator with fit-error accumulation. A load word is taken
// while idle and leaves the state unchanged. An evaluate or error word first
// builds the powers of (1-t) and the binomial row, n being the degree
// (num_points-1, clamped to 1..MAX_POINTS-1), then makes one pass per
// control point through the weight multiplier pipeline that reads the
// control point memory (four stages), then rounds, and for error words
// takes difference, square and accumulate. Only evaluate words and last
// error words have a result; such a word then hands it to the output
// register, and waits while that register still holds an unaccepted word.
// A finished word waits in the output register while the next word is taken.
// Control points live in a memory with a registered read; unwritten slots read 0.
`include "assert_macros.svh"

module bezier_curve_eval_error import bezier_pkg::*; #(
	parameter int MAX_POINTS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [3:0]         cfg_wr_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         command,
	input  logic [2:0]         point_index,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_y,
	input  logic [16:0]        param_t,
	input  logic               first_sample,
	input  logic               last_sample,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] curve_x,
	output logic signed [31:0] curve_y,
	output logic [63:0]        error_x,
	output logic [63:0]        error_y,
	output logic               is_error_total
);

	localparam int IW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 3);
	localparam int BW = MAX_POINTS;
	localparam int AW = 49 + $clog2(MAX_POINTS);

	state_t state_q;
	logic [3:0] num_points_q;

	logic [1:0]        cmd_q;
	logic [31:0]       x_q, y_q;
	logic [16:0]       t_q, u_q;
	logic              first_q, last_q;
	logic [IW-1:0]     n_q;
	logic [CW-1:0]     cnt_q;

	logic [31:0]       mem_x [MAX_POINTS];
	logic [31:0]       mem_y [MAX_POINTS];
	logic [MAX_POINTS-1:0] vld_q;
	logic [31:0]       rdx_q, rdy_q;
	logic              rdv_q;

	logic [16:0]       up_arr [MAX_POINTS];
	logic [16:0]       up_run_q, tp_run_q;
	logic [BW-1:0]     row_q [MAX_POINTS];

	logic              v_s1, v_s2, v_s3;
	logic [16:0]       p_s1, w_s2;
	logic [BW-1:0]     b_s1;
	logic signed [31:0] px_s2, py_s2;
	logic signed [49:0] mx_s3, my_s3;
	logic signed [AW-1:0] accx_q, accy_q;

	logic signed [31:0] cx_q, cy_q;
	logic [31:0]       adx_q, ady_q;
	logic [63:0]       sqx_q, sqy_q;
	logic [63:0]       sum_x_q, sum_y_q;
	logic [63:0]       ex_q, ey_q;
	logic              tot_q;

	logic              ov_q;
	logic signed [31:0] ocx_q, ocy_q;
	logic [63:0]       oex_q, oey_q;
	logic              otot_q;

	logic              accept, issue;
	logic [IW-1:0]     ci;
	logic [IW-1:0]     n_cfg;
	logic [16:0]       t_cl;
	logic [16:0]       up_nxt, tp_nxt;
	logic [BW+16:0]    wfull;
	logic signed [31:0] rx, ry;
	logic signed [32:0] dx, dy;
	logic [64:0]       addx, addy;
	logic [63:0]       nsx, nsy;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign ci       = cnt_q[IW-1:0];
	assign issue    = (state_q == ST_WGT) && (cnt_q <= CW'(n_q));
	assign t_cl     = (param_t > ONE_Q16) ? ONE_Q16 : param_t;
	assign up_nxt   = rnd16(up_run_q, u_q);
	assign tp_nxt   = rnd16(tp_run_q, t_q);
	assign wfull    = (BW + 17)'(b_s1) * (BW + 17)'(p_s1);

	always_comb begin
		if (num_points_q < 4'd2) begin
			n_cfg = IW'(1);
		end else if ({1'b0, num_points_q} > 5'(MAX_POINTS)) begin
			n_cfg = IW'(MAX_POINTS - 1);
		end else begin
			n_cfg = IW'(num_points_q - 4'd1);
		end
	end

	// floor((acc + half) / 2^16), clipped to the signed 32-bit range
	always_comb begin
		logic signed [AW-1:0] bx, by;
		bx = accx_q + AW'(32768);
		by = accy_q + AW'(32768);
		if (bx[AW-1:47] == {(AW-47){bx[47]}}) begin
			rx = bx[47:16];
		end else begin
			rx = bx[AW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end
		if (by[AW-1:47] == {(AW-47){by[47]}}) begin
			ry = by[47:16];
		end else begin
			ry = by[AW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end
	end

	always_comb begin
		dx   = {x_q[31], x_q} - {cx_q[31], cx_q};
		dy   = {y_q[31], y_q} - {cy_q[31], cy_q};
		addx = {1'b0, sum_x_q} + {1'b0, sqx_q};
		addy = {1'b0, sum_y_q} + {1'b0, sqy_q};
		if (first_q) begin
			nsx = '0;
			nsy = '0;
		end else if (!last_q) begin
			nsx = addx[64] ? '1 : addx[63:0];
			nsy = addy[64] ? '1 : addy[63:0];
		end else begin
			nsx = sum_x_q;
			nsy = sum_y_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_points_q <= 4'd4;
		end else if (cfg_wr_en) begin
			num_points_q <= cfg_wr_data;
		end
	end

	// control point memory
	always_ff @(posedge clk) begin
		if (accept && command == CMD_LOAD && {1'b0, point_index} < 5'(MAX_POINTS)) begin
			mem_x[IW'(point_index)] <= coord_x;
			mem_y[IW'(point_index)] <= coord_y;
		end
		if (issue) begin
			rdx_q <= mem_x[ci];
			rdy_q <= mem_y[ci];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rdv_q <= 1'b0;
		end else begin
			if (accept && command == CMD_LOAD &&
					{1'b0, point_index} < 5'(MAX_POINTS)) begin
				vld_q[IW'(point_index)] <= 1'b1;
			end
			if (issue) begin
				rdv_q <= vld_q[ci];
			end
		end
	end

	// powers of (1-t) and binomial row
	always_ff @(posedge clk) begin
		if (accept) begin
			up_arr[0] <= ONE_Q16;
			up_run_q  <= ONE_Q16;
			tp_run_q  <= ONE_Q16;
			row_q[0]  <= BW'(1);
			for (int j = 1; j < MAX_POINTS; j++) begin
				row_q[j] <= '0;
			end
		end else if (state_q == ST_POW) begin
			up_arr[ci] <= up_nxt;
			up_run_q   <= up_nxt;
			for (int j = 1; j < MAX_POINTS; j++) begin
				row_q[j] <= row_q[j] + row_q[j-1];
			end
		end else if (issue) begin
			tp_run_q <= tp_nxt;
		end
	end

	// weight pipeline payload
	always_ff @(posedge clk) begin
		if (issue) begin
			p_s1 <= rnd16(tp_run_q, up_arr[n_q - ci]);
			b_s1 <= row_q[ci];
		end
		w_s2  <= (wfull > (BW + 17)'(ONE_Q16)) ? ONE_Q16 : wfull[16:0];
		px_s2 <= rdv_q ? rdx_q : '0;
		py_s2 <= rdv_q ? rdy_q : '0;
		mx_s3 <= $signed({1'b0, w_s2}) * px_s2;
		my_s3 <= $signed({1'b0, w_s2}) * py_s2;
		if (accept) begin
			accx_q <= '0;
			accy_q <= '0;
		end else if (v_s3) begin
			accx_q <= accx_q + AW'(mx_s3);
			accy_q <= accy_q + AW'(my_s3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// item registers and the tail of the computation
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= command;
			x_q     <= coord_x;
			y_q     <= coord_y;
			t_q     <= t_cl;
			u_q     <= ONE_Q16 - t_cl;
			first_q <= first_sample;
			last_q  <= last_sample;
			n_q     <= n_cfg;
		end
		if (state_q == ST_RND) begin
			cx_q  <= rx;
			cy_q  <= ry;
			ex_q  <= '0;
			ey_q  <= '0;
			tot_q <= 1'b0;
		end
		if (state_q == ST_DIF) begin
			adx_q <= dx[32] ? 32'(-dx) : dx[31:0];
			ady_q <= dy[32] ? 32'(-dy) : dy[31:0];
		end
		if (state_q == ST_SQ) begin
			sqx_q <= 64'(adx_q) * 64'(adx_q);
			sqy_q <= 64'(ady_q) * 64'(ady_q);
		end
		if (state_q == ST_ACC) begin
			ex_q  <= nsx;
			ey_q  <= nsy;
			tot_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x_q <= '0;
			sum_y_q <= '0;
		end else if (state_q == ST_ACC) begin
			sum_x_q <= nsx;
			sum_y_q <= nsy;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cnt_q <= CW'(1);
					if (accept && (command == CMD_EVAL || command == CMD_ERR)) begin
						state_q <= ST_POW;
					end
				end
				ST_POW: begin
					if (cnt_q == CW'(n_q)) begin
						cnt_q   <= '0;
						state_q <= ST_WGT;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_WGT: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(n_q) + CW'(3)) begin
						state_q <= ST_RND;
					end
				end
				ST_RND: state_q <= (cmd_q == CMD_ERR) ? ST_DIF : ST_OUT;
				ST_DIF: state_q <= ST_SQ;
				ST_SQ:  state_q <= ST_ACC;
				ST_ACC: state_q <= last_q ? ST_OUT : ST_IDLE;
				ST_OUT: begin
					if (!ov_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (state_q == ST_OUT && (!ov_q || out_ready)) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && (!ov_q || out_ready)) begin
			ocx_q  <= cx_q;
			ocy_q  <= cy_q;
			oex_q  <= ex_q;
			oey_q  <= ey_q;
			otot_q <= tot_q;
		end
	end

	assign out_valid      = ov_q;
	assign curve_x        = ocx_q;
	assign curve_y        = ocy_q;
	assign error_x        = oex_q;
	assign error_y        = oey_q;
	assign is_error_total = otot_q;

	`ASSERT_AT(a_out_from_done, $rose(out_valid) |-> $past(state_q == ST_OUT), "word without done")
	`ASSERT_NEVER(a_pipe_state, v_s3 && state_q != ST_WGT, "weight pipe runs outside pass")
	`ASSERT_AT(a_sum_hold, state_q != ST_ACC |=> $stable(sum_x_q) && $stable(sum_y_q), "sum moved")
	`ASSERT_NEVER(a_eval_zero, out_valid && !is_error_total && (error_x != 64'd0 || error_y != 64'd0), "eval word carries sums")

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import bezier_pkg::*;

	typedef struct packed {
		cmd_t               command;
		logic [2:0]         point_index;
		logic signed [31:0] coord_x;
		logic signed [31:0] coord_y;
		logic [16:0]        param_t;
		logic               first_sample;
		logic               last_sample;
	} word_t;

	typedef struct packed {
		logic signed [31:0] curve_x;
		logic signed [31:0] curve_y;
		logic [63:0]        error_x;
		logic [63:0]        error_y;
		logic               is_error_total;
	} curve_res_t;

	localparam int NPTS = 8;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [3:0] cfg_wr_data = 4'd0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] command = 2'd0;
	logic [2:0] point_index = 3'd0;
	logic signed [31:0] coord_x = 32'sd0;
	logic signed [31:0] coord_y = 32'sd0;
	logic [16:0] param_t = 17'd0;
	logic first_sample = 1'b0;
	logic last_sample = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] curve_x;
	logic signed [31:0] curve_y;
	logic [63:0] error_x;
	logic [63:0] error_y;
	logic is_error_total;

	bezier_curve_eval_error dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .point_index(point_index),
		.coord_x(coord_x), .coord_y(coord_y), .param_t(param_t),
		.first_sample(first_sample), .last_sample(last_sample),
		.out_valid(out_valid), .out_ready(out_ready),
		.curve_x(curve_x), .curve_y(curve_y),
		.error_x(error_x), .error_y(error_y), .is_error_total(is_error_total)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [3:0]  pts_cfg;
	logic [31:0] ctl_x[NPTS];
	logic [31:0] ctl_y[NPTS];
	logic [63:0] acc_x, acc_y;

	word_t      pending_words[$];
	curve_res_t expected_points[$];
	int  errors = 0;
	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	bit  hold_off = 1'b0;
	int  hold_cycles = 0;
	int  idle_cycles = 0;

	function automatic logic signed [31:0] round_sat32(input logic signed [63:0] acc);
		logic signed [63:0] r;
		r = (acc + 64'sd32768) >>> 16;
		if (r > 64'sd2147483647) r = 64'sd2147483647;
		if (r < -64'sd2147483648) r = -64'sd2147483648;
		return r[31:0];
	endfunction

	task automatic eval_bezier(input logic [16:0] t_in,
			output logic signed [31:0] cx, output logic signed [31:0] cy);
		logic [63:0] t, u, w, binom;
		logic [63:0] tp[NPTS];
		logic [63:0] up[NPTS];
		logic signed [63:0] ax, ay;
		int np, n;
		t = (t_in > 17'd65536) ? 64'd65536 : 64'(t_in);
		u = 64'd65536 - t;
		np = (pts_cfg < 2) ? 2 : ((pts_cfg > NPTS) ? NPTS : int'(pts_cfg));
		n = np - 1;
		tp[0] = 64'd65536;
		up[0] = 64'd65536;
		for (int i = 1; i <= n; i++) begin
			tp[i] = (tp[i-1] * t + 64'd32768) >> 16;
			up[i] = (up[i-1] * u + 64'd32768) >> 16;
		end
		binom = 1;
		ax = 0;
		ay = 0;
		for (int i = 0; i <= n; i++) begin
			w = binom * ((tp[i] * up[n-i] + 64'd32768) >> 16);
			if (w > 64'd65536) w = 64'd65536;
			ax += $signed(w) * 64'($signed(ctl_x[i]));
			ay += $signed(w) * 64'($signed(ctl_y[i]));
			binom = binom * 64'(n - i) / 64'(i + 1);
		end
		cx = round_sat32(ax);
		cy = round_sat32(ay);
	endtask

	function automatic logic [63:0] sq_diff(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [63:0] d;
		d = 64'(a) - 64'(b);
		if (d < 0) d = -d;
		return d * d;
	endfunction

	function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = 65'(a) + 65'(b);
		return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
	endfunction

	task automatic predict_word(input word_t wd);
		logic signed [31:0] cx, cy;
		curve_res_t r;
		case (wd.command)
			CMD_LOAD: begin
				ctl_x[wd.point_index] = wd.coord_x;
				ctl_y[wd.point_index] = wd.coord_y;
			end
			CMD_EVAL: begin
				eval_bezier(wd.param_t, cx, cy);
				r = '{cx, cy, 64'd0, 64'd0, 1'b0};
				expected_points.push_back(r);
			end
			CMD_ERR: begin
				eval_bezier(wd.param_t, cx, cy);
				if (wd.first_sample) begin
					acc_x = 0;
					acc_y = 0;
				end
				if (!wd.first_sample && !wd.last_sample) begin
					acc_x = add_sat(acc_x, sq_diff(wd.coord_x, cx));
					acc_y = add_sat(acc_y, sq_diff(wd.coord_y, cy));
				end
				if (wd.last_sample) begin
					r = '{cx, cy, acc_x, acc_y, 1'b1};
					expected_points.push_back(r);
				end
			end
			default: ;
		endcase
	endtask

	// driver
	always @(posedge clk) begin
		word_t wd;
		if (arst_n) begin
			if (!in_valid || in_ready) begin
				if (in_valid) predict_word({cmd_t'(command), point_index, coord_x,
					coord_y, param_t, first_sample, last_sample});
				if (pending_words.size() > 0 &&
						$urandom_range(99) >= send_idle_pct) begin
					wd = pending_words.pop_front();
					in_valid <= 1'b1;
					command <= wd.command;
					point_index <= wd.point_index;
					coord_x <= wd.coord_x;
					coord_y <= wd.coord_y;
					param_t <= wd.param_t;
					first_sample <= wd.first_sample;
					last_sample <= wd.last_sample;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor and receiver stalls
	always @(posedge clk) begin
		curve_res_t exp_r;
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (out_valid && out_ready) begin
				if (expected_points.size() == 0) begin
					$display("%0t: unexpected word x=%h y=%h", $time, curve_x, curve_y);
					errors++;
				end else begin
					exp_r = expected_points.pop_front();
					if (curve_x !== exp_r.curve_x) begin
						$display("%0t: curve_x exp %h got %h", $time, exp_r.curve_x, curve_x);
						errors++;
					end
					if (curve_y !== exp_r.curve_y) begin
						$display("%0t: curve_y exp %h got %h", $time, exp_r.curve_y, curve_y);
						errors++;
					end
					if (error_x !== exp_r.error_x) begin
						$display("%0t: error_x exp %h got %h", $time, exp_r.error_x, error_x);
						errors++;
					end
					if (error_y !== exp_r.error_y) begin
						$display("%0t: error_y exp %h got %h", $time, exp_r.error_y, error_y);
						errors++;
					end
					if (is_error_total !== exp_r.is_error_total) begin
						$display("%0t: is_error_total exp %b got %b", $time,
							exp_r.is_error_total, is_error_total);
						errors++;
					end
				end
			end
			if (hold_off) begin
				out_ready <= 1'b0;
				hold_cycles <= hold_cycles + 1;
			end else begin
				hold_cycles <= 0;
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom_range(32'h0004_0000);
			3: return -$urandom_range(32'h0004_0000);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [16:0] rand_t();
		case ($urandom_range(7))
			0: return 17'd0;
			1: return 17'd65536;
			2: return 17'h1FFFF;
			3: return 17'($urandom_range(17'h1FFFF, 17'd65537));
			default: return 17'($urandom_range(65536));
		endcase
	endfunction

	function automatic word_t make_word(input cmd_t c, input logic [2:0] idx,
			input logic [31:0] x, input logic [31:0] y, input logic [16:0] t,
			input logic fs, input logic ls);
		word_t wd;
		wd = '{c, idx, x, y, t, fs, ls};
		return wd;
	endfunction

	task automatic wait_drained(input int settle);
		while (pending_words.size() > 0 || in_valid || expected_points.size() > 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_points_cfg(input logic [3:0] v);
		wait_drained(40);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		pts_cfg = v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// one error sweep: first, the given number of middle words, last, with random content
	task automatic queue_sweep(input int middles);
		pending_words.push_back(make_word(CMD_ERR, $urandom, rand_coord(), rand_coord(),
			rand_t(), 1'b1, 1'b0));
		for (int i = 0; i < middles; i++)
			pending_words.push_back(make_word(CMD_ERR, $urandom, rand_coord(),
				rand_coord(), rand_t(), 1'b0, 1'b0));
		pending_words.push_back(make_word(CMD_ERR, $urandom, rand_coord(), rand_coord(),
			rand_t(), 1'b0, 1'b1));
	endtask

	task automatic queue_random(input int count);
		int k;
		int m;
		for (int i = 0; i < count; ) begin
			k = $urandom_range(9);
			if (k < 3) begin
				pending_words.push_back(make_word(CMD_LOAD, $urandom, rand_coord(),
					rand_coord(), $urandom, $urandom, $urandom));
				i++;
			end else if (k < 6) begin
				pending_words.push_back(make_word(CMD_EVAL, $urandom, rand_coord(),
					rand_coord(), rand_t(), $urandom, $urandom));
				i++;
			end else if (k < 9) begin
				m = k - 6 + $urandom_range(4);
				queue_sweep(m);
				i += m + 2;
			end else begin
				// noise: unused command or stray marks
				if ($urandom_range(1))
					pending_words.push_back(make_word(CMD_NONE, $urandom, $urandom,
						$urandom, $urandom, $urandom, $urandom));
				else
					pending_words.push_back(make_word(CMD_ERR, $urandom, rand_coord(),
						rand_coord(), rand_t(), $urandom, $urandom));
				i++;
			end
		end
	endtask

	initial begin
		logic [3:0] settings[6] = '{4'd2, 4'd8, 4'd0, 4'd15, 4'd5, 4'd3};
		pts_cfg = 4'd4;
		acc_x = 0;
		acc_y = 0;
		for (int i = 0; i < NPTS; i++) begin
			ctl_x[i] = 0;
			ctl_y[i] = 0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset-state eval, extremes, all commands, special cases
		pending_words.push_back(make_word(CMD_EVAL, 0, 0, 0, 17'd32768, 0, 0));
		for (int i = 0; i < NPTS; i++)
			pending_words.push_back(make_word(CMD_LOAD, 3'(i),
				i[0] ? 32'h7FFF_FFFF : 32'h8000_0000,
				i[1] ? 32'h8000_0000 : 32'h7FFF_FFFF, 17'h1FFFF, 1, 1));
		pending_words.push_back(make_word(CMD_EVAL, 0, 0, 0, 17'd0, 0, 0));
		pending_words.push_back(make_word(CMD_EVAL, 0, 0, 0, 17'd65536, 0, 0));
		pending_words.push_back(make_word(CMD_EVAL, 0, 0, 0, 17'h1FFFF, 0, 0));
		pending_words.push_back(make_word(CMD_NONE, 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			17'h1FFFF, 1, 1));
		pending_words.push_back(make_word(CMD_ERR, 0, 0, 0, 17'd100, 1, 1));
		pending_words.push_back(make_word(CMD_ERR, 0, 0, 0, 17'd0, 1, 0));
		pending_words.push_back(make_word(CMD_ERR, 0, 32'h8000_0000, 32'h8000_0000,
			17'd0, 0, 0));
		pending_words.push_back(make_word(CMD_ERR, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			17'd65536, 0, 0));
		pending_words.push_back(make_word(CMD_ERR, 0, 32'h8000_0000, 32'h8000_0000,
			17'd0, 0, 0));
		pending_words.push_back(make_word(CMD_ERR, 0, 0, 0, 17'd5, 0, 1));
		// saturation: many huge differences in one sweep
		pending_words.push_back(make_word(CMD_ERR, 0, 0, 0, 17'd0, 1, 0));
		for (int i = 0; i < 6; i++)
			pending_words.push_back(make_word(CMD_ERR, 0, 32'h8000_0000, 32'h8000_0000,
				17'd65536, 0, 0));
		pending_words.push_back(make_word(CMD_ERR, 0, 0, 0, 17'd0, 0, 1));
		wait_drained(40);

		for (int ph = 0; ph < 6; ph++) begin
			write_points_cfg(settings[ph]);
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 50; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 50; end
				default: begin send_idle_pct = 18; recv_stall_pct = 18; end
			endcase
			queue_random(200);
			if (ph == 0) begin
				// long receiver hold-off while input keeps coming
				hold_off = 1'b1;
				while (hold_cycles < 600) @(posedge clk);
				hold_off = 1'b0;
			end
		end

		wait_drained(60);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
